// File: hw/rtl/rpnp_pkg.sv
// ----------------------------------------------------------------------------
// rpnp_pkg
// Shared types and constants for the radix-prefixed number parser.
// ----------------------------------------------------------------------------
package rpnp_pkg;

    // Working width of the accumulator and the value it stands for.
    localparam int VALUE_WIDTH = 32;
    // Width of the value field on the result stream.
    localparam int OUT_WIDTH   = 32;
    // One accumulation step (times at most sixteen, plus a digit) is exact at
    // this width.
    localparam int EXT_WIDTH   = VALUE_WIDTH + 5;

    // Largest positive signed value, held at the extended width.
    localparam logic [EXT_WIDTH-1:0] SMAX_EXT =
        EXT_WIDTH'({1'b0, {(VALUE_WIDTH-1){1'b1}}});

    // Character codes.
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_CASE_BIT  = 8'h20;
    localparam logic [7:0] CH_LOWER_B   = 8'h62;
    localparam logic [7:0] CH_LOWER_O   = 8'h6F;
    localparam logic [7:0] CH_LOWER_D   = 8'h64;
    localparam logic [7:0] CH_LOWER_X   = 8'h78;
    localparam logic [7:0] CH_DIGIT_LO  = 8'd48;
    localparam logic [7:0] CH_DIGIT_HI  = 8'd57;
    localparam logic [7:0] CH_UPPER_LO  = 8'd65;
    localparam logic [7:0] CH_UPPER_HI  = 8'd70;
    localparam logic [7:0] CH_LOWER_LO  = 8'd97;
    localparam logic [7:0] CH_LOWER_HI  = 8'd102;
    localparam logic [7:0] CH_UPPER_OFS = 8'd55;
    localparam logic [7:0] CH_LOWER_OFS = 8'd87;

    typedef enum logic [1:0] {
        BASE_BIN = 2'd0,
        BASE_OCT = 2'd1,
        BASE_DEC = 2'd2,
        BASE_HEX = 2'd3
    } base_t;

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_BASE   = 2'd1,
        PH_DIGITS = 2'd2
    } phase_t;

    // Classification of one character.
    typedef struct packed {
        logic       is_minus;
        logic       letter_ok;
        base_t      base;
        logic       digit_ok;
        logic [3:0] digit;
    } char_class_t;

    // One finished result.
    typedef struct packed {
        logic [OUT_WIDTH-1:0] value;
        logic                 valid_res;
        logic                 overflow;
    } result_t;

endpackage

// File: hw/rtl/rpnp_char_class.sv
// ----------------------------------------------------------------------------
// rpnp_char_class
// Sorts one ASCII character into minus sign, base letter or digit.
// ----------------------------------------------------------------------------
module rpnp_char_class
    import rpnp_pkg::*;
(
    input  logic [7:0]  char_code,
    output char_class_t cls
);

    logic [7:0] lower;

    assign lower = char_code | CH_CASE_BIT;

    always_comb
    begin
        cls           = '0;
        cls.base      = BASE_BIN;
        cls.is_minus  = (char_code == CH_MINUS);

        case (lower)
            CH_LOWER_B:
            begin
                cls.letter_ok = 1'b1;
                cls.base      = BASE_BIN;
            end
            CH_LOWER_O:
            begin
                cls.letter_ok = 1'b1;
                cls.base      = BASE_OCT;
            end
            CH_LOWER_D:
            begin
                cls.letter_ok = 1'b1;
                cls.base      = BASE_DEC;
            end
            CH_LOWER_X:
            begin
                cls.letter_ok = 1'b1;
                cls.base      = BASE_HEX;
            end
            default:
            begin
                cls.letter_ok = 1'b0;
            end
        endcase

        if (char_code >= CH_DIGIT_LO && char_code <= CH_DIGIT_HI)
        begin
            cls.digit_ok = 1'b1;
            cls.digit    = 4'(char_code - CH_DIGIT_LO);
        end
        else if (char_code >= CH_UPPER_LO && char_code <= CH_UPPER_HI)
        begin
            cls.digit_ok = 1'b1;
            cls.digit    = 4'(char_code - CH_UPPER_OFS);
        end
        else if (char_code >= CH_LOWER_LO && char_code <= CH_LOWER_HI)
        begin
            cls.digit_ok = 1'b1;
            cls.digit    = 4'(char_code - CH_LOWER_OFS);
        end
    end

endmodule

// File: hw/rtl/rpnp_token_core.sv
// ----------------------------------------------------------------------------
// rpnp_token_core
// Token state machine and accumulator; forms the result on the last word.
// ----------------------------------------------------------------------------
module rpnp_token_core
    import rpnp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic        last,
    input  char_class_t cls,
    output logic        res_load,
    output result_t     res
);

    phase_t                 phase_reg, phase_next, phase_upd;
    logic                   neg_reg, neg_next, neg_upd;
    base_t                  base_reg, base_next, base_upd;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next, acc_upd;
    logic                   bad_reg, bad_next, bad_upd;
    logic                   wrap_reg, wrap_next, wrap_upd;
    logic                   seen_reg, seen_next;

    logic [EXT_WIDTH-1:0]   acc_ext;
    logic [EXT_WIDTH-1:0]   prod;
    logic                   digit_fits;
    logic                   ok;
    logic signed [VALUE_WIDTH-1:0] signed_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            neg_reg   <= 1'b0;
            base_reg  <= BASE_BIN;
            acc_reg   <= '0;
            bad_reg   <= 1'b0;
            wrap_reg  <= 1'b0;
            seen_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            base_reg  <= base_next;
            acc_reg   <= acc_next;
            bad_reg   <= bad_next;
            wrap_reg  <= wrap_next;
            seen_reg  <= seen_next;
        end
    end

    // Shift-add by the base: the exact product plus digit, before wrapping.
    assign acc_ext = EXT_WIDTH'(acc_reg);

    always_comb
    begin
        case (base_reg)
            BASE_BIN: prod = (acc_ext << 1);
            BASE_OCT: prod = (acc_ext << 3);
            BASE_DEC: prod = (acc_ext << 3) + (acc_ext << 1);
            BASE_HEX: prod = (acc_ext << 4);
            default:  prod = acc_ext;
        endcase
        prod = prod + EXT_WIDTH'(cls.digit);
    end

    always_comb
    begin
        case (base_reg)
            BASE_BIN: digit_fits = (cls.digit < 4'd2);
            BASE_OCT: digit_fits = (cls.digit < 4'd8);
            BASE_DEC: digit_fits = (cls.digit < 4'd10);
            BASE_HEX: digit_fits = 1'b1;
            default:  digit_fits = 1'b0;
        endcase
    end

    always_comb
    begin
        phase_upd = phase_reg;
        neg_upd   = neg_reg;
        base_upd  = base_reg;
        acc_upd   = acc_reg;
        bad_upd   = bad_reg;
        wrap_upd  = wrap_reg;

        // After an error the rest of the token is ignored.
        if (!bad_reg)
        begin
            case (phase_reg)
                PH_START:
                begin
                    if (cls.is_minus)
                    begin
                        neg_upd   = 1'b1;
                        phase_upd = PH_BASE;
                    end
                    else if (cls.letter_ok)
                    begin
                        base_upd  = cls.base;
                        phase_upd = PH_DIGITS;
                    end
                    else
                    begin
                        bad_upd = 1'b1;
                    end
                end
                PH_BASE:
                begin
                    if (cls.letter_ok)
                    begin
                        base_upd  = cls.base;
                        phase_upd = PH_DIGITS;
                    end
                    else
                    begin
                        bad_upd = 1'b1;
                    end
                end
                PH_DIGITS:
                begin
                    if (!cls.digit_ok || !digit_fits)
                    begin
                        bad_upd = 1'b1;
                    end
                    else
                    begin
                        if (prod > SMAX_EXT)
                        begin
                            wrap_upd = 1'b1;
                        end
                        acc_upd = prod[VALUE_WIDTH-1:0];
                    end
                end
                default:
                begin
                    phase_upd = PH_START;
                end
            endcase
        end

        // A single-character token is never valid.
        ok         = !bad_upd && seen_reg && (phase_upd == PH_DIGITS);
        signed_val = neg_upd ? (VALUE_WIDTH'(0) - acc_upd) : acc_upd;

        res           = '0;
        res.valid_res = ok;
        if (ok)
        begin
            res.value    = OUT_WIDTH'(signed_val);
            res.overflow = wrap_upd;
        end

        res_load = step && last;

        phase_next = phase_reg;
        neg_next   = neg_reg;
        base_next  = base_reg;
        acc_next   = acc_reg;
        bad_next   = bad_reg;
        wrap_next  = wrap_reg;
        seen_next  = seen_reg;

        if (step)
        begin
            if (last)
            begin
                phase_next = PH_START;
                neg_next   = 1'b0;
                base_next  = BASE_BIN;
                acc_next   = '0;
                bad_next   = 1'b0;
                wrap_next  = 1'b0;
                seen_next  = 1'b0;
            end
            else
            begin
                phase_next = phase_upd;
                neg_next   = neg_upd;
                base_next  = base_upd;
                acc_next   = acc_upd;
                bad_next   = bad_upd;
                wrap_next  = wrap_upd;
                seen_next  = 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/rpnp_out_reg.sv
// ----------------------------------------------------------------------------
// rpnp_out_reg
// Result register holding one word for the master-side stream.
// ----------------------------------------------------------------------------
module rpnp_out_reg
    import rpnp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  result_t              res,
    output logic                 space,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [OUT_WIDTH-1:0] m_tdata,
    output logic [1:0]           m_tuser
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    // The register can take a word if it is empty or its word leaves now.
    assign space = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg.value;
    assign m_tuser  = {res_reg.overflow, res_reg.valid_res};

endmodule

// File: hw/rtl/radix_prefixed_number_parser.sv
// ----------------------------------------------------------------------------
// radix_prefixed_number_parser
// Parses a radix-prefixed signed integer token from a character stream.
// ----------------------------------------------------------------------------
// Throughput: one character word per cycle, sustained, also across tokens, while the
// result register has room; a last character waits in the input register until it
// has, then its result is loaded into the result register, which drives m_tvalid.
// Reset: rst_n is asynchronous and active low; it empties both registers and
// rearms the parser for the start of a fresh token.
// ----------------------------------------------------------------------------
module radix_prefixed_number_parser
    import rpnp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    // Character stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] char_code
    input  logic                 s_tlast,   // last character of the token

    // Result stream, one word per token.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_WIDTH-1:0] m_tdata,   // [31:0] value (signed)
    output logic [1:0]           m_tuser    // [0] valid_res, [1] overflow
);

    // Input register. A character is held here while it is classified and
    // folded into the token state.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_char_reg;
    logic       in_last_reg;

    logic        s_accept;
    logic        step;
    logic        out_space;
    logic        res_load;
    char_class_t cls;
    result_t     res;

    // A character that does not end the token never needs the result
    // register, so only a last character waits for room downstream.
    assign step     = in_valid_reg && (!in_last_reg || out_space);
    assign s_tready = !in_valid_reg || step;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Sort the held character into sign, base letter or digit.
    rpnp_char_class u_char_class (
        .char_code (in_char_reg),
        .cls       (cls)
    );

    // Token state: sign, base, accumulator, error and wrap flags. On the
    // last character it presents the finished result and rearms.
    rpnp_token_core u_token_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .last     (in_last_reg),
        .cls      (cls),
        .res_load (res_load),
        .res      (res)
    );

    // Result register on the master side.
    rpnp_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_load),
        .res      (res),
        .space    (out_space),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// File: verif/tb_radix_prefixed_number_parser.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_radix_prefixed_number_parser
// Self-checking bench for the radix-prefixed number parser. Character words
// are driven on the slave stream, and each accepted word is run through a
// behavioural parser kept in this bench. Every result word on the master
// stream is compared field by field against the oldest prediction. Both
// streams are throttled at random, apart from one stretch at full rate.
// ----------------------------------------------------------------------------
module tb_radix_prefixed_number_parser;
    import rpnp_pkg::*;

    typedef logic [7:0] char_q_t[$];

    localparam int  CLK_PERIOD    = 12;
    localparam int  RESET_CYCLES  = 8;
    localparam int  IDLE_PERCENT  = 21;
    localparam int  REPORT_LIMIT  = 10;
    localparam int  DRAIN_CYCLES  = 20000;
    localparam int  SETTLE_CYCLES = 8;
    localparam int  RUN_LIMIT_NS  = 2400000;
    localparam logic [63:0] SMAX = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;    // [7:0] char_code
    logic                 s_tlast;    // last character of the token
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUT_WIDTH-1:0] m_tdata;    // [31:0] value (signed)
    logic [1:0]           m_tuser;    // [0] valid_res, [1] overflow

    // Shadow copy of the parser state, advanced once per accepted word.
    phase_t                 parse_phase;
    logic                   parse_negative;
    base_t                  parse_base;
    logic [VALUE_WIDTH-1:0] parse_acc;
    logic                   parse_bad;
    logic                   parse_wrapped;
    logic [1:0]             parse_seen;

    // Results predicted but not yet seen on the master stream, oldest first.
    result_t parsed_q[$];
    int      mismatch_cnt;
    // When set, neither stream is throttled.
    bit      calm_phase;

    radix_prefixed_number_parser u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // A hard ceiling on the run, well beyond the slowest legitimate pass.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Test completed with failures");
        $finish;
    end

    // Back-pressure on the result stream: ready drops about a fifth of the time,
    // except during the calm phase when it is held high.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= calm_phase || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Puts the shadow parser back to its rearmed state, as after reset or
    // after the final character of a token.
    function automatic void rearm_parser();
        parse_phase    = PH_START;
        parse_negative = 1'b0;
        parse_base     = BASE_BIN;
        parse_acc      = '0;
        parse_bad      = 1'b0;
        parse_wrapped  = 1'b0;
        parse_seen     = 2'd0;
    endfunction

    // Advances the shadow parser by one accepted character and, on the
    // final character of a token, queues the result it must produce.
    function automatic void parse_char(input logic [7:0] c, input logic lst);
        logic [7:0]             folded;
        logic                   is_letter;
        base_t                  letter_base;
        logic [4:0]             digit;
        logic [4:0]             radix;
        logic [63:0]            exact;
        logic                   first;
        logic                   ok;
        logic [VALUE_WIDTH-1:0] v;
        result_t                res;

        first = (parse_seen == 2'd0);
        if (parse_seen < 2'd2)
            parse_seen = parse_seen + 2'd1;

        // Base letters are recognised in either case by folding to lower.
        folded      = c | CH_CASE_BIT;
        is_letter   = 1'b1;
        letter_base = BASE_BIN;
        case (folded)
            CH_LOWER_B: letter_base = BASE_BIN;
            CH_LOWER_O: letter_base = BASE_OCT;
            CH_LOWER_D: letter_base = BASE_DEC;
            CH_LOWER_X: letter_base = BASE_HEX;
            default:    is_letter = 1'b0;
        endcase

        // A value of sixteen marks a character that is no digit at all,
        // so it fails the check against every base.
        if (c >= CH_DIGIT_LO && c <= CH_DIGIT_HI)
            digit = 5'(c - CH_DIGIT_LO);
        else if (c >= CH_UPPER_LO && c <= CH_UPPER_HI)
            digit = 5'(c - CH_UPPER_OFS);
        else if (c >= CH_LOWER_LO && c <= CH_LOWER_HI)
            digit = 5'(c - CH_LOWER_OFS);
        else
            digit = 5'd16;

        case (parse_base)
            BASE_BIN: radix = 5'd2;
            BASE_OCT: radix = 5'd8;
            BASE_DEC: radix = 5'd10;
            default:  radix = 5'd16;
        endcase

        if (!parse_bad)
        begin
            case (parse_phase)
                PH_START:
                begin
                    if (c == CH_MINUS)
                    begin
                        parse_negative = 1'b1;
                        parse_phase    = PH_BASE;
                    end
                    else if (is_letter)
                    begin
                        parse_base  = letter_base;
                        parse_phase = PH_DIGITS;
                    end
                    else
                        parse_bad = 1'b1;
                end
                PH_BASE:
                begin
                    if (is_letter)
                    begin
                        parse_base  = letter_base;
                        parse_phase = PH_DIGITS;
                    end
                    else
                        parse_bad = 1'b1;
                end
                default:
                begin
                    if (digit >= radix)
                        parse_bad = 1'b1;
                    else
                    begin
                        // The overflow flag is sticky once the exact sum
                        // passes the largest positive signed value.
                        exact = 64'(parse_acc) * 64'(radix) + 64'(digit);
                        if (exact > SMAX)
                            parse_wrapped = 1'b1;
                        parse_acc = exact[VALUE_WIDTH-1:0];
                    end
                end
            endcase
        end

        if (lst)
        begin
            ok = !parse_bad && !first && (parse_phase == PH_DIGITS);
            v  = '0;
            if (ok)
                v = parse_negative ? -parse_acc : parse_acc;
            res.value     = OUT_WIDTH'($signed(v));
            res.valid_res = ok;
            res.overflow  = ok && parse_wrapped;
            parsed_q.push_back(res);
            rearm_parser();
        end
    endfunction

    // Result checker. Each result word taken from the master stream is
    // matched against the oldest outstanding prediction.
    always @(posedge clk)
    begin
        result_t want;

        if (rst_n && m_tvalid && m_tready)
        begin
            if (parsed_q.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_LIMIT)
                    $display("Unexpected result: value=%0d valid=%0b overflow=%0b",
                             $signed(m_tdata), m_tuser[0], m_tuser[1]);
            end
            else
            begin
                want = parsed_q.pop_front();
                if (m_tdata !== want.value || m_tuser[0] !== want.valid_res ||
                    m_tuser[1] !== want.overflow)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_LIMIT)
                        $display("Mismatch: expected value=%0d valid=%0b overflow=%0b, %s%0d %s%0b %s%0b",
                                 $signed(want.value), want.valid_res, want.overflow,
                                 "got value=", $signed(m_tdata), "valid=", m_tuser[0],
                                 "overflow=", m_tuser[1]);
                end
            end
        end
    end

    // Sends one character word. It is entered at a falling edge and returns
    // at the falling edge after the word has been taken. Each cycle before
    // the word is idle with the same small chance, so back-to-back words
    // keep valid high unless an idle cycle is drawn.
    task automatic send_char(input logic [7:0] c, input logic lst);
        while (!calm_phase && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= lst;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        parse_char(c, lst);
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    task automatic send_token(input char_q_t tok);
        for (int i = 0; i < tok.size(); i++)
            send_char(tok[i], i == tok.size() - 1);
    endtask

    // Builds one random token. Most are well formed with random digits,
    // some are well formed and then damaged, the rest are raw noise.
    function automatic char_q_t make_token();
        char_q_t    tok;
        string      letters;
        int         kind;
        int         pick;
        int         radix;
        int         n_digits;
        int         d;
        int         pos;

        letters = "bBoOdDxX";
        kind    = $urandom_range(0, 99);
        if (kind < 90)
        begin
            if ($urandom_range(0, 1))
                tok.push_back(CH_MINUS);
            pick = $urandom_range(0, 7);
            tok.push_back(letters[pick]);
            case (pick / 2)
                0:       radix = 2;
                1:       radix = 8;
                2:       radix = 10;
                default: radix = 16;
            endcase
            // Short numbers mostly, some longer; the longest can wrap in any base.
            pos = $urandom_range(0, 99);
            if (pos < 75)
                n_digits = $urandom_range(0, 6);
            else if (pos < 96)
                n_digits = $urandom_range(7, 14);
            else
                n_digits = $urandom_range(30, 34);
            for (int i = 0; i < n_digits; i++)
            begin
                d = $urandom_range(0, radix - 1);
                if (d < 10)
                    tok.push_back(8'(CH_DIGIT_LO + d));
                else if ($urandom_range(0, 1))
                    tok.push_back(8'(CH_UPPER_OFS + d));
                else
                    tok.push_back(8'(CH_LOWER_OFS + d));
            end
            if (kind >= 80)
            begin
                pos = $urandom_range(0, tok.size() - 1);
                if ($urandom_range(0, 1))
                    tok[pos] = 8'($urandom_range(0, 255));
                else
                    tok.insert(pos, CH_MINUS);
            end
        end
        else
        begin
            n_digits = $urandom_range(1, 4);
            for (int i = 0; i < n_digits; i++)
                tok.push_back(8'($urandom_range(0, 255)));
        end
        return tok;
    endfunction

    // A token of one character is rejected whatever that character is.
    task automatic test_single_char();
        send_text("d");
        send_text("-");
        send_text("7");
    endtask

    // A minus and a base letter with no digits after them are accepted with a value
    // of zero, and a minus in front of zero still gives zero.
    task automatic test_prefix_and_zero();
        send_text("-x");
        send_text("-d0");
    endtask

    // Each base letter (b, O, D, and x in both cases), with hex digits in both cases.
    task automatic test_bases();
        send_text("b1");
        send_text("O7");
        send_text("D9");
        send_text("Xa");
        send_text("xF");
    endtask

    // Largest positive value, then the most negative one, which also sets
    // the overflow flag because the magnitude passes the signed maximum.
    task automatic test_value_extremes();
        send_text("x7fffffff");
        send_text("-x80000000");
    endtask

    // Doubled or misplaced minus, digits out of range for the base, a null
    // character and a character above the ASCII range. In each
    // three-character token the middle character is the error, and the
    // character after it must be ignored.
    task automatic test_bad_chars();
        send_text("--");
        send_text("d-");
        send_text("o8");
        send_text("b2");
        send_text("dA1");
        send_char(CH_LOWER_X, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(CH_DIGIT_LO, 1'b1);
        send_char(CH_LOWER_D, 1'b0);
        send_char(8'hFF, 1'b1);
    endtask

    task automatic test_random_tokens(input int char_budget, input bit quiet);
        char_q_t tok;
        int      sent;

        calm_phase = quiet;
        sent       = 0;
        while (sent < char_budget)
        begin
            tok = make_token();
            send_token(tok);
            sent += tok.size();
        end
        calm_phase = 1'b0;
    endtask

    // Main sequence: one reset, the directed checks, then random tokens
    // with throttling and a final stretch at full rate.
    initial
    begin
        int waited;

        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        calm_phase   = 1'b0;
        mismatch_cnt = 0;
        rearm_parser();

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_single_char();
        test_prefix_and_zero();
        test_bases();
        test_value_extremes();
        test_bad_chars();
        test_random_tokens(1200, 1'b0);
        test_random_tokens(550, 1'b1);

        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        // Let the outstanding results drain, then keep the checker running so that
        // any stray word would still be caught.
        waited = 0;
        while (parsed_q.size() != 0 && waited < DRAIN_CYCLES)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0 && parsed_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
